>>> rtl/bsl_pkg.sv
// shared constants, node record and sequencer states for the bucket sorter
// no dependencies; the interfaces, bsl_bucket and the top module refer to this package by scoped names
package bsl_pkg;

	localparam int MAX_ITEMS   = 32;
	localparam int VALUE_LIMIT = 64;

	// field widths fixed by the channel payloads
	localparam int KEY_W = 6;
	localparam int CNT_W = 6;
	localparam int BKT_W = 5;

	// node pointer width follows the node memory depth
	localparam int IDX_W = $clog2(MAX_ITEMS);

	// one entry of the node memory: key plus its forward link
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             link_valid;
		logic [IDX_W-1:0] link;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_HKEY,
		ST_WALK,
		ST_LINK,
		ST_SCAN,
		ST_EHEAD,
		ST_ENODE
	} state_t;

endpackage

>>> rtl/bsl_if.sv
// valid/ready channel interfaces for keys in, sorted keys out and the count register
// depends on bsl_pkg for the field widths
interface bsl_key_if;
	logic                       valid;
	logic                       ready;
	logic [bsl_pkg::KEY_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface bsl_sorted_if;
	logic                       valid;
	logic                       ready;
	logic [bsl_pkg::KEY_W-1:0]  sorted_value;
	logic [bsl_pkg::BKT_W-1:0]  bucket_index;
	logic                       last_flag;

	modport source (output valid, output sorted_value, output bucket_index,
		output last_flag, input ready);
	modport sink   (input valid, input sorted_value, input bucket_index,
		input last_flag, output ready);
endinterface

interface bsl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bsl_pkg::CNT_W-1:0]  item_count;

	modport source (output valid, output item_count, input ready);
	modport sink   (input valid, input item_count, output ready);
endinterface

>>> rtl/bsl_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module bsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bsl_bucket.sv
// bucket selection: key * count / VALUE_LIMIT, saturated to the last bucket in use
// depends on bsl_pkg
module bsl_bucket (
	input  logic [bsl_pkg::KEY_W-1:0] value,
	input  logic [bsl_pkg::CNT_W-1:0] active_cnt,
	output logic [bsl_pkg::BKT_W-1:0] bucket
);

	localparam int PROD_W = bsl_pkg::KEY_W + bsl_pkg::CNT_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;
	logic [PROD_W-1:0] cnt_ext;

	// scale the key into the bucket range
	always_comb begin
		prod    = PROD_W'(value) * PROD_W'(active_cnt);
		quot    = prod / PROD_W'(bsl_pkg::VALUE_LIMIT);
		cnt_ext = PROD_W'(active_cnt);
		if (quot >= cnt_ext) begin
			bucket = bsl_pkg::BKT_W'(cnt_ext - PROD_W'(1));
		end else begin
			bucket = bsl_pkg::BKT_W'(quot);
		end
	end

endmodule

>>> rtl/bucket_sort_linked_buckets.sv
// Bucket sorter with linked buckets. Load item_count keys one request at a time; each
// key is linked in ascending order into bucket key*count/VALUE_LIMIT, kept in a node
// memory (key plus next pointer) and a bucket head memory, both with one read port.
// A key into an empty bucket is written as the bucket's head; otherwise the head node is
// read, a key not above the head key becomes the new head, and else the block walks the
// bucket and links the key after the last entry not above it: each step of the walk
// is one read of the node memory. After the last key of the run is inserted the block
// streams out all keys, bucket 0 first, last_flag on the final one; a stall on the
// output holds the streamout. No key request is taken during the streamout, and writing
// item_count (taken only between requests) abandons the run in progress.
module bucket_sort_linked_buckets (
	input logic             clk,
	input logic             arst_n,
	bsl_key_if.sink         keys,
	bsl_sorted_if.source    sorted,
	bsl_cfg_if.sink         cfg
);

	localparam int NODE_W = $bits(bsl_pkg::node_t);

	bsl_pkg::state_t              state_q, state_d;
	logic [bsl_pkg::CNT_W-1:0]    item_count_q;
	logic [bsl_pkg::CNT_W-1:0]    loaded_q;
	logic [bsl_pkg::CNT_W-1:0]    loaded_inc;
	logic [bsl_pkg::CNT_W-1:0]    active_cnt;
	logic [bsl_pkg::MAX_ITEMS-1:0] hv_q;
	logic [bsl_pkg::MAX_ITEMS-1:0] hv_above;

	// item being inserted
	logic [bsl_pkg::KEY_W-1:0]    v_q;
	logic [bsl_pkg::BKT_W-1:0]    b_q;
	logic [bsl_pkg::IDX_W-1:0]    k_q;
	logic [bsl_pkg::IDX_W-1:0]    prev_q;
	bsl_pkg::node_t               prev_node_q;
	logic [bsl_pkg::BKT_W-1:0]    b_in;

	// streamout
	logic [bsl_pkg::BKT_W-1:0]    scan_q;
	logic                         out_valid_q;
	logic [bsl_pkg::KEY_W-1:0]    out_key_q;
	logic [bsl_pkg::BKT_W-1:0]    out_bkt_q;
	logic                         out_last_q;

	// memory ports
	logic                         head_we, head_re;
	logic [bsl_pkg::BKT_W-1:0]    head_wa, head_ra;
	logic [bsl_pkg::IDX_W-1:0]    head_wd, head_rd;
	logic                         node_we, node_re;
	logic [bsl_pkg::IDX_W-1:0]    node_wa, node_ra;
	bsl_pkg::node_t               node_wd, node_rd;

	// sequencer strobes
	logic key_acc, cfg_acc;
	logic head_set, take_head, step_prev, ins_done, emit_load, emit_last, emit_done;
	logic scan_inc;

	// keys per run, clamped to the supported range
	always_comb begin
		if (item_count_q == '0) begin
			active_cnt = bsl_pkg::CNT_W'(1);
		end else if (item_count_q > bsl_pkg::CNT_W'(bsl_pkg::MAX_ITEMS)) begin
			active_cnt = bsl_pkg::CNT_W'(bsl_pkg::MAX_ITEMS);
		end else begin
			active_cnt = item_count_q;
		end
	end

	bsl_bucket u_bucket (
		.value      (keys.value),
		.active_cnt (active_cnt),
		.bucket     (b_in)
	);

	bsl_ram #(.WIDTH(bsl_pkg::IDX_W), .DEPTH(bsl_pkg::MAX_ITEMS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_wa),
		.wdata (head_wd),
		.re    (head_re),
		.raddr (head_ra),
		.rdata (head_rd)
	);

	bsl_ram #(.WIDTH(NODE_W), .DEPTH(bsl_pkg::MAX_ITEMS)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_wa),
		.wdata (node_wd),
		.re    (node_re),
		.raddr (node_ra),
		.rdata (node_rd)
	);

	// handshakes
	assign cfg.ready  = (state_q == bsl_pkg::ST_IDLE);
	assign keys.ready = (state_q == bsl_pkg::ST_IDLE) && !cfg.valid;
	assign key_acc    = keys.valid && keys.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;

	assign sorted.valid        = out_valid_q;
	assign sorted.sorted_value = out_key_q;
	assign sorted.bucket_index = out_bkt_q;
	assign sorted.last_flag    = out_last_q;

	assign loaded_inc = loaded_q + bsl_pkg::CNT_W'(1);
	// non-empty buckets after the one being streamed
	assign hv_above   = (hv_q >> scan_q) >> 1;
	assign emit_last  = !node_rd.link_valid && (hv_above == '0);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		head_we   = 1'b0;
		head_wa   = b_q;
		head_wd   = k_q;
		head_re   = 1'b0;
		head_ra   = b_in;
		node_we   = 1'b0;
		node_wa   = k_q;
		node_wd   = '{key: v_q, link_valid: 1'b0, link: '0};
		node_re   = 1'b0;
		node_ra   = node_rd.link;
		head_set  = 1'b0;
		take_head = 1'b0;
		step_prev = 1'b0;
		ins_done  = 1'b0;
		emit_load = 1'b0;
		emit_done = 1'b0;
		scan_inc  = 1'b0;
		case (state_q)
			bsl_pkg::ST_IDLE: begin
				if (key_acc) begin
					head_re = 1'b1;
					state_d = bsl_pkg::ST_HEAD;
				end
			end
			// empty bucket: new node becomes the head, else fetch the head node
			bsl_pkg::ST_HEAD: begin
				if (!hv_q[b_q]) begin
					head_we  = 1'b1;
					head_set = 1'b1;
					node_we  = 1'b1;
					ins_done = 1'b1;
				end else begin
					node_re   = 1'b1;
					node_ra   = head_rd;
					take_head = 1'b1;
					state_d   = bsl_pkg::ST_HKEY;
				end
			end
			// compare against the head key
			bsl_pkg::ST_HKEY: begin
				if (v_q <= node_rd.key) begin
					node_we  = 1'b1;
					node_wd  = '{key: v_q, link_valid: 1'b1, link: prev_q};
					head_we  = 1'b1;
					ins_done = 1'b1;
				end else if (node_rd.link_valid) begin
					node_re = 1'b1;
					state_d = bsl_pkg::ST_WALK;
				end else begin
					node_we = 1'b1;
					node_wd = '{key: v_q, link_valid: 1'b0, link: node_rd.link};
					state_d = bsl_pkg::ST_LINK;
				end
			end
			// node_rd is the successor of prev; stop before the first greater key
			bsl_pkg::ST_WALK: begin
				if (node_rd.key > v_q) begin
					node_we = 1'b1;
					node_wd = '{key: v_q, link_valid: prev_node_q.link_valid,
						link: prev_node_q.link};
					state_d = bsl_pkg::ST_LINK;
				end else begin
					step_prev = 1'b1;
					if (node_rd.link_valid) begin
						node_re = 1'b1;
					end else begin
						node_we = 1'b1;
						node_wd = '{key: v_q, link_valid: 1'b0, link: node_rd.link};
						state_d = bsl_pkg::ST_LINK;
					end
				end
			end
			// point the predecessor at the new node
			bsl_pkg::ST_LINK: begin
				node_we  = 1'b1;
				node_wa  = prev_q;
				node_wd  = '{key: prev_node_q.key, link_valid: 1'b1, link: k_q};
				ins_done = 1'b1;
			end
			// find the next non-empty bucket
			bsl_pkg::ST_SCAN: begin
				if (hv_q[scan_q]) begin
					head_re = 1'b1;
					head_ra = scan_q;
					state_d = bsl_pkg::ST_EHEAD;
				end else begin
					scan_inc = 1'b1;
				end
			end
			bsl_pkg::ST_EHEAD: begin
				node_re = 1'b1;
				node_ra = head_rd;
				state_d = bsl_pkg::ST_ENODE;
			end
			// hand one key to the output register, then follow its link
			bsl_pkg::ST_ENODE: begin
				if (!out_valid_q || sorted.ready) begin
					emit_load = 1'b1;
					if (node_rd.link_valid) begin
						node_re = 1'b1;
					end else if (emit_last) begin
						emit_done = 1'b1;
						state_d   = bsl_pkg::ST_IDLE;
					end else begin
						scan_inc = 1'b1;
						state_d  = bsl_pkg::ST_SCAN;
					end
				end
			end
			default: begin
				state_d = bsl_pkg::ST_IDLE;
			end
		endcase
		// end of an insertion: wait for the next key or start the streamout
		if (ins_done) begin
			if (loaded_inc == active_cnt) begin
				state_d = bsl_pkg::ST_SCAN;
			end else begin
				state_d = bsl_pkg::ST_IDLE;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: count register, fill count, head valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= bsl_pkg::CNT_W'(1);
			loaded_q     <= '0;
			hv_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_acc) begin
				item_count_q <= cfg.item_count;
				loaded_q     <= '0;
				hv_q         <= '0;
			end else if (emit_done) begin
				loaded_q <= '0;
				hv_q     <= '0;
			end else begin
				if (ins_done) begin
					loaded_q <= loaded_inc;
				end
				if (head_set) begin
					hv_q[b_q] <= 1'b1;
				end
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (sorted.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the insertion and the streamout
	always_ff @(posedge clk) begin
		if (key_acc) begin
			v_q <= keys.value;
			b_q <= b_in;
			k_q <= bsl_pkg::IDX_W'(loaded_q);
		end
		if (take_head) begin
			prev_q <= head_rd;
		end else if (step_prev) begin
			prev_q <= prev_node_q.link;
		end
		if (state_q == bsl_pkg::ST_HKEY || step_prev) begin
			prev_node_q <= node_rd;
		end
		if (ins_done) begin
			scan_q <= '0;
		end else if (scan_inc) begin
			scan_q <= scan_q + bsl_pkg::BKT_W'(1);
		end
		if (emit_load) begin
			out_key_q  <= node_rd.key;
			out_bkt_q  <= scan_q;
			out_last_q <= emit_last;
		end
	end

	// the fill count never reaches the run length while waiting for a key
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsl_pkg::ST_IDLE) |-> (loaded_q < active_cnt))
		else $error("fill count reached run length while idle");

	// every node passed during the walk holds a key not above the new one
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsl_pkg::ST_WALK) |-> (prev_node_q.key <= v_q))
		else $error("walk passed a greater key");

	// the node memory is never read and written at one entry in the same cycle
	a_node_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(node_we && node_re && (node_wa == node_ra)))
		else $error("node memory read and write collide");

	// the final key leaves the buckets empty and the block idle
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |=> (hv_q == '0) && (loaded_q == '0) && (state_q == bsl_pkg::ST_IDLE))
		else $error("buckets not cleared after the final key");

endmodule
